@@ rtl/udp_flow_counter_table_assert.svh @@
// assertion macros for the udp flow counter table
// expects clk and arst_n in the scope of each use
`ifndef UDP_FLOW_COUNTER_TABLE_ASSERT_SVH
`define UDP_FLOW_COUNTER_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UFCT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufct assertion failed");

// antecedent implies consequent in the next cycle
`define UFCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufct assertion failed");

`endif

@@ rtl/ufct_pkg.sv @@
// shared types, constants and classification for the udp flow counter table
// no dependencies
`default_nettype none

package ufct_pkg;

	localparam int FLOW_ENTRIES_DEF = 256;

	localparam logic [15:0] PREFIX_BYTES     = 16'd82;
	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTOCOL_UDP     = 8'd17;
	localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
	localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;
	localparam int          DROP_REASONS     = 5;

	localparam logic [2:0] STAT_COUNTED    = 3'd0;
	localparam logic [2:0] STAT_SHORT      = 3'd1;
	localparam logic [2:0] STAT_NOT_IPV4   = 3'd2;
	localparam logic [2:0] STAT_NOT_UDP    = 3'd3;
	localparam logic [2:0] STAT_HDR_SHORT  = 3'd4;
	localparam logic [2:0] STAT_TABLE_FULL = 3'd5;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic [3:0]  header_words;
		logic [15:0] udp_length;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [31:0] interface_index;
	} frame_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  flow_slot;
		logic [63:0] packet_total;
		logic [63:0] byte_total;
		logic [63:0] reason_total;
	} result_t;

	typedef struct packed {
		logic [63:0] address_pair;
		logic [63:0] ports_and_interface;
	} flow_key_t;

	typedef struct packed {
		logic [63:0] packets;
		logic [63:0] bytes;
	} flow_cnt_t;

	function automatic logic [2:0] classify(frame_t f);
		logic [2:0] s;
		if (f.frame_length < PREFIX_BYTES) s = STAT_SHORT;
		else if (f.ethertype != ETHERTYPE_IPV4) s = STAT_NOT_IPV4;
		else if (f.ip_protocol != PROTOCOL_UDP) s = STAT_NOT_UDP;
		else if (f.header_words < MIN_HEADER_WORDS) s = STAT_HDR_SHORT;
		else s = STAT_COUNTED;
		return s;
	endfunction

	function automatic flow_key_t make_key(frame_t f);
		flow_key_t k;
		k.address_pair        = {f.source_address, f.dest_address};
		k.ports_and_interface = {f.source_port, f.dest_port, f.interface_index};
		return k;
	endfunction

	function automatic logic [15:0] payload_of(logic [15:0] udp_length);
		logic [15:0] p;
		if (udp_length >= UDP_HEADER_BYTES) p = udp_length - UDP_HEADER_BYTES;
		else p = 16'd0;
		return p;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ufct_key_mem.sv @@
// flow key memory with registered read and exact-match compare
// depends on ufct_pkg
`default_nettype none

module ufct_key_mem #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  wire                    clk,
	input  wire                    wr_en,
	input  wire [IW-1:0]           wr_addr,
	input  ufct_pkg::flow_key_t    wr_key,
	input  wire                    rd_en,
	input  wire [IW-1:0]           rd_addr,
	input  ufct_pkg::flow_key_t    probe,
	output logic                   match
);
	import ufct_pkg::*;

	flow_key_t mem [DEPTH];
	flow_key_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_key;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign match = (rd_q == probe);

endmodule

`default_nettype wire

@@ rtl/ufct_cnt_mem.sv @@
// per-flow packet and byte counter memory, registered read
// depends on ufct_pkg
`default_nettype none

module ufct_cnt_mem #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  wire                    clk,
	input  wire                    wr_en,
	input  wire [IW-1:0]           wr_addr,
	input  ufct_pkg::flow_cnt_t    wr_data,
	input  wire                    rd_en,
	input  wire [IW-1:0]           rd_addr,
	output ufct_pkg::flow_cnt_t    rd_data
);
	import ufct_pkg::*;

	flow_cnt_t mem [DEPTH];
	flow_cnt_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

@@ rtl/udp_flow_counter_table.sv @@
// dropped frames go from accept through the drop state to done; other frames search the
// key memory, one stored flow per cycle, via its single read port. a hit adds a counter read
// and two passes through the shared 64-bit adder; a miss adds a flow, or drops if full.
// one item at a time; busy stays high until done. results are not stalled.
// reset clears the state, flow count and drop counters at once; no clearing pass.
// top level sequencer; depends on ufct_pkg, ufct_key_mem, ufct_cnt_mem and the assert header
`default_nettype none

`include "udp_flow_counter_table_assert.svh"

module udp_flow_counter_table #(
	parameter int FLOW_ENTRIES = ufct_pkg::FLOW_ENTRIES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  ufct_pkg::frame_t    frame,
	output logic                busy,
	output logic                done,
	output ufct_pkg::result_t   result
);
	import ufct_pkg::*;

	localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CW = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(FLOW_ENTRIES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_CRD  = 3'd2;
	localparam logic [2:0] S_PKT  = 3'd3;
	localparam logic [2:0] S_BYT  = 3'd4;
	localparam logic [2:0] S_DROP = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [IW-1:0] idx_s1;
	logic          done_q;
	logic [63:0]   drop_q [DROP_REASONS];

	flow_key_t     key_q;
	logic [15:0]   payload_q;
	logic [2:0]    reason_q;
	logic [IW-1:0] slot_q;
	logic [63:0]   pkt_sum_q;
	result_t       res_q;

	logic          match;
	logic          issue;
	logic          miss;
	logic          hit;
	logic [2:0]    fstat;
	logic [2:0]    didx;
	logic [63:0]   add_a;
	logic [63:0]   add_b;
	logic [63:0]   sum;
	flow_cnt_t     cnt_rd;
	flow_cnt_t     cnt_wr;
	logic          cnt_wr_en;
	logic [IW-1:0] cnt_wr_addr;
	logic          key_wr_en;

	assign fstat = classify(frame);
	assign issue = (state_q == S_SRCH) && !hit && (idx_q < used_q);
	assign hit   = (state_q == S_SRCH) && pend_s1 && match;
	assign miss  = (state_q == S_SRCH) && !pend_s1 && !(idx_q < used_q);
	assign didx  = reason_q - 3'd1;

	assign key_wr_en = miss && (used_q != FULL);

	ufct_key_mem #(.DEPTH(FLOW_ENTRIES), .IW(IW)) u_key (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (used_q[IW-1:0]),
		.wr_key  (key_q),
		.rd_en   (issue),
		.rd_addr (idx_q[IW-1:0]),
		.probe   (key_q),
		.match   (match)
	);

	// shared adder
	always_comb begin
		unique case (state_q)
			S_PKT: begin
				add_a = cnt_rd.packets;
				add_b = 64'd1;
			end
			S_BYT: begin
				add_a = cnt_rd.bytes;
				add_b = {48'd0, payload_q};
			end
			S_DROP: begin
				add_a = drop_q[didx];
				add_b = 64'd1;
			end
			default: begin
				add_a = 64'd0;
				add_b = 64'd0;
			end
		endcase
	end
	assign sum = add_a + add_b;

	always_comb begin
		if (state_q == S_BYT) begin
			cnt_wr_en      = 1'b1;
			cnt_wr_addr    = slot_q;
			cnt_wr.packets = pkt_sum_q;
			cnt_wr.bytes   = sum;
		end else begin
			cnt_wr_en      = key_wr_en;
			cnt_wr_addr    = used_q[IW-1:0];
			cnt_wr.packets = 64'd1;
			cnt_wr.bytes   = {48'd0, payload_q};
		end
	end

	ufct_cnt_mem #(.DEPTH(FLOW_ENTRIES), .IW(IW)) u_cnt (
		.clk     (clk),
		.wr_en   (cnt_wr_en),
		.wr_addr (cnt_wr_addr),
		.wr_data (cnt_wr),
		.rd_en   (state_q == S_CRD),
		.rd_addr (slot_q),
		.rd_data (cnt_rd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < DROP_REASONS; i++) begin
				drop_q[i] <= 64'd0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= (fstat == STAT_COUNTED) ? S_SRCH : S_DROP;
					end
				end
				S_SRCH: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						state_q <= S_CRD;
					end else if (issue) begin
						pend_s1 <= 1'b1;
						idx_q   <= idx_q + CW'(1);
					end else if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else if (used_q == FULL) begin
						state_q <= S_DROP;
					end else begin
						used_q  <= used_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CRD: state_q <= S_PKT;
				S_PKT: state_q <= S_BYT;
				S_BYT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DROP: begin
					drop_q[didx] <= sum;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_q     <= make_key(frame);
					payload_q <= payload_of(frame.udp_length);
					reason_q  <= fstat;
				end
			end
			S_SRCH: begin
				if (hit) begin
					slot_q <= idx_s1;
				end
				if (issue) begin
					idx_s1 <= idx_q[IW-1:0];
				end
				if (miss) begin
					if (used_q == FULL) begin
						reason_q <= STAT_TABLE_FULL;
					end else begin
						res_q.status       <= STAT_COUNTED;
						res_q.flow_slot    <= 8'(used_q[IW-1:0]);
						res_q.packet_total <= 64'd1;
						res_q.byte_total   <= {48'd0, payload_q};
						res_q.reason_total <= 64'd0;
					end
				end
			end
			S_PKT: pkt_sum_q <= sum;
			S_BYT: begin
				res_q.status       <= STAT_COUNTED;
				res_q.flow_slot    <= 8'(slot_q);
				res_q.packet_total <= pkt_sum_q;
				res_q.byte_total   <= sum;
				res_q.reason_total <= 64'd0;
			end
			S_DROP: begin
				res_q.status       <= reason_q;
				res_q.flow_slot    <= 8'd0;
				res_q.packet_total <= 64'd0;
				res_q.byte_total   <= 64'd0;
				res_q.reason_total <= sum;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	`UFCT_ASSERT_SAME(a_used_bound, 1'b1, used_q <= FULL)
	`UFCT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`UFCT_ASSERT_SAME(a_done_idle, done, !busy)
	`UFCT_ASSERT_SAME(a_counted_reason, done && result.status == STAT_COUNTED,
		result.reason_total == 64'd0)
	`UFCT_ASSERT_SAME(a_drop_zero, done && result.status != STAT_COUNTED,
		result.packet_total == 64'd0 && result.reason_total != 64'd0)

endmodule

`default_nettype wire
